// ===== hdl/scp_pkg.sv =====
// Shared types and fixed widths for the segment closest-points block.
package scp_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int DOT_W      = 2 * DIFF_W + 1;
   localparam int WIDE_W     = 2 * DOT_W + 1;
   localparam int LIMIT_W    = 20;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [DOT_W-1:0]      dot_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } req_type;

   typedef struct packed {
      coord_type foot_a_x;
      coord_type foot_a_y;
      coord_type foot_b_x;
      coord_type foot_b_y;
      logic      interior_feet;
   } rsp_type;

   // Start points and directions, carried along the pipeline to the foot stage.
   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      diff_type  dax;
      diff_type  day;
      diff_type  dbx;
      diff_type  dby;
      logic      interior;
   } geo_type;

endpackage

// ===== hdl/scp_frac.sv =====
// Pipelined restoring divider that forms a saturated unsigned fraction num/den.
module scp_frac #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  scp_pkg::wide_type             num,
   input  scp_pkg::wide_type             den,
   output logic [FRACTION_BITS:0]        quo
);
   import scp_pkg::*;

   localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

   logic [WIDE_W-1:0]        rem_ff [0:FRACTION_BITS];
   logic [WIDE_W-1:0]        dvs_ff [0:FRACTION_BITS];
   logic [FRACTION_BITS-1:0] qbits_ff [0:FRACTION_BITS];
   logic                     frc_ff [0:FRACTION_BITS];
   logic [FRACTION_BITS:0]   fval_ff [0:FRACTION_BITS];

   logic zero_in;
   logic one_in;

   always_comb begin
      zero_in = (den <= 0) || (num <= 0);
      one_in  = !zero_in && (num >= den);
   end

   always_ff @(posedge clock) begin
      rem_ff[0]   <= num;
      dvs_ff[0]   <= den;
      qbits_ff[0] <= '0;
      frc_ff[0]   <= zero_in || one_in;
      fval_ff[0]  <= one_in ? ONE : '0;
   end

   // One quotient bit per stage.
   for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_step
      logic [WIDE_W:0] dbl;
      logic [WIDE_W:0] dif;
      logic            ge;
      always_comb begin
         dbl = {rem_ff[i], 1'b0};
         dif = dbl - {1'b0, dvs_ff[i]};
         ge  = dbl >= {1'b0, dvs_ff[i]};
      end
      always_ff @(posedge clock) begin
         rem_ff[i+1]   <= ge ? dif[WIDE_W-1:0] : dbl[WIDE_W-1:0];
         dvs_ff[i+1]   <= dvs_ff[i];
         qbits_ff[i+1] <= {qbits_ff[i][FRACTION_BITS-2:0], ge};
         frc_ff[i+1]   <= frc_ff[i];
         fval_ff[i+1]  <= fval_ff[i];
      end
   end

   assign quo = frc_ff[FRACTION_BITS] ? fval_ff[FRACTION_BITS]
                                      : {1'b0, qbits_ff[FRACTION_BITS]};

endmodule

// ===== hdl/segment_closest_points_2d.sv =====
// Top level: closest points between two 2D segments, fully pipelined.
// One beat per cycle is accepted while busy is low; the two parameter divisions
// set the depth: one quotient bit per stage. Reset clears all valid bits and
// sets the parallel threshold limit_ff to 1; busy is high only during reset,
// and the receiver cannot stall, so results are never held.
module segment_closest_points_2d #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  scp_pkg::req_type                    req_item,
   output logic                                rsp_strobe,
   output scp_pkg::rsp_type                    rsp_item,
   input  logic                                csr_we,
   input  logic [scp_pkg::LIMIT_W-1:0]         csr_wdata
);
   import scp_pkg::*;

   localparam int PW = FRACTION_BITS + 2 + DIFF_W;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

   // Parallel threshold register.
   logic [LIMIT_W-1:0] limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_W'(1);
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   assign busy = reset;

   // Valid bits for the front stages.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic accept;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
      end else begin
         v1_ff <= accept; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
      end
   end

   // Stage 1: directions and the offset between the start points.
   geo_type  geo1_ff, geo2_ff, geo3_ff, geo4_ff, geo5_ff, geo6_ff, geo7_ff;
   diff_type wx1_ff, wy1_ff;
   always_ff @(posedge clock) begin
      geo1_ff.ax       <= req_item.a_start_x;
      geo1_ff.ay       <= req_item.a_start_y;
      geo1_ff.bx       <= req_item.b_start_x;
      geo1_ff.by       <= req_item.b_start_y;
      geo1_ff.dax      <= DIFF_W'(req_item.a_end_x) - DIFF_W'(req_item.a_start_x);
      geo1_ff.day      <= DIFF_W'(req_item.a_end_y) - DIFF_W'(req_item.a_start_y);
      geo1_ff.dbx      <= DIFF_W'(req_item.b_end_x) - DIFF_W'(req_item.b_start_x);
      geo1_ff.dby      <= DIFF_W'(req_item.b_end_y) - DIFF_W'(req_item.b_start_y);
      geo1_ff.interior <= 1'b1;
      wx1_ff <= DIFF_W'(req_item.a_start_x) - DIFF_W'(req_item.b_start_x);
      wy1_ff <= DIFF_W'(req_item.a_start_y) - DIFF_W'(req_item.b_start_y);
   end

   // Stage 2: the coordinate products of the five dot products.
   logic signed [2*DIFF_W-1:0] paa_x_ff, paa_y_ff, pab_x_ff, pab_y_ff, pbb_x_ff, pbb_y_ff;
   logic signed [2*DIFF_W-1:0] paw_x_ff, paw_y_ff, pbw_x_ff, pbw_y_ff;
   always_ff @(posedge clock) begin
      paa_x_ff <= geo1_ff.dax * geo1_ff.dax;
      paa_y_ff <= geo1_ff.day * geo1_ff.day;
      pab_x_ff <= geo1_ff.dax * geo1_ff.dbx;
      pab_y_ff <= geo1_ff.day * geo1_ff.dby;
      pbb_x_ff <= geo1_ff.dbx * geo1_ff.dbx;
      pbb_y_ff <= geo1_ff.dby * geo1_ff.dby;
      paw_x_ff <= geo1_ff.dax * wx1_ff;
      paw_y_ff <= geo1_ff.day * wy1_ff;
      pbw_x_ff <= geo1_ff.dbx * wx1_ff;
      pbw_y_ff <= geo1_ff.dby * wy1_ff;
      geo2_ff  <= geo1_ff;
   end

   // Stage 3: the dot products a, b, c, d and e.
   dot_type a3_ff, b3_ff, c3_ff, d3_ff, e3_ff;
   always_ff @(posedge clock) begin
      a3_ff <= DOT_W'(paa_x_ff) + DOT_W'(paa_y_ff);
      b3_ff <= DOT_W'(pab_x_ff) + DOT_W'(pab_y_ff);
      c3_ff <= DOT_W'(pbb_x_ff) + DOT_W'(pbb_y_ff);
      d3_ff <= DOT_W'(paw_x_ff) + DOT_W'(paw_y_ff);
      e3_ff <= DOT_W'(pbw_x_ff) + DOT_W'(pbw_y_ff);
      geo3_ff <= geo2_ff;
   end

   // Stage 4: the wide cross products.
   wide_type ac4_ff, bb4_ff, be4_ff, cd4_ff, ae4_ff, bd4_ff;
   dot_type  a4_ff, b4_ff, c4_ff, d4_ff, e4_ff;
   always_ff @(posedge clock) begin
      ac4_ff <= a3_ff * c3_ff;
      bb4_ff <= b3_ff * b3_ff;
      be4_ff <= b3_ff * e3_ff;
      cd4_ff <= c3_ff * d3_ff;
      ae4_ff <= a3_ff * e3_ff;
      bd4_ff <= b3_ff * d3_ff;
      a4_ff <= a3_ff; b4_ff <= b3_ff; c4_ff <= c3_ff; d4_ff <= d3_ff; e4_ff <= e3_ff;
      geo4_ff <= geo3_ff;
   end

   // Stage 5: the denominator, both numerators and the parallel test.
   wide_type den5_ff, sn5_ff, tn5_ff;
   dot_type  a5_ff, b5_ff, c5_ff, d5_ff, e5_ff;
   logic     par5_ff;
   wide_type den_c;
   always_comb begin
      den_c = ac4_ff - bb4_ff;
   end
   always_ff @(posedge clock) begin
      den5_ff <= den_c;
      sn5_ff  <= be4_ff - cd4_ff;
      tn5_ff  <= ae4_ff - bd4_ff;
      par5_ff <= den_c < $signed(WIDE_W'(limit_ff));
      a5_ff <= a4_ff; b5_ff <= b4_ff; c5_ff <= c4_ff; d5_ff <= d4_ff; e5_ff <= e4_ff;
      geo5_ff <= geo4_ff;
   end

   // Stage 6: choose the s branch (parallel pair, or clamp of s at 0 or 1).
   wide_type sn6_in, sd6_in, tn6_in, td6_in;
   logic     ins6_in;
   geo_type  geo6_in;
   wide_type sn6_ff, sd6_ff, tn6_ff, td6_ff;
   dot_type  a6_ff;
   logic signed [DOT_W:0] nd6_ff, bd6_ff;
   always_comb begin
      sn6_in  = sn5_ff;
      sd6_in  = den5_ff;
      tn6_in  = tn5_ff;
      td6_in  = den5_ff;
      ins6_in = 1'b1;
      if (par5_ff) begin
         sn6_in = '0;
         sd6_in = WIDE_W'(1);
         tn6_in = WIDE_W'(e5_ff);
         td6_in = WIDE_W'(c5_ff);
      end else if (sn5_ff < 0) begin
         sn6_in  = '0;
         tn6_in  = WIDE_W'(e5_ff);
         td6_in  = WIDE_W'(c5_ff);
         ins6_in = 1'b0;
      end else if (den5_ff < sn5_ff) begin
         sn6_in  = den5_ff;
         tn6_in  = WIDE_W'(e5_ff) + WIDE_W'(b5_ff);
         td6_in  = WIDE_W'(c5_ff);
         ins6_in = 1'b0;
      end
      geo6_in          = geo5_ff;
      geo6_in.interior = ins6_in;
   end
   always_ff @(posedge clock) begin
      sn6_ff <= sn6_in;
      sd6_ff <= sd6_in;
      tn6_ff <= tn6_in;
      td6_ff <= td6_in;
      a6_ff  <= a5_ff;
      nd6_ff <= -((DOT_W+1)'(d5_ff));
      bd6_ff <= (DOT_W+1)'(b5_ff) - (DOT_W+1)'(d5_ff);
      geo6_ff <= geo6_in;
   end

   // Stage 7: clamp t at 0 or 1 and, if it acted, search s against A alone.
   wide_type sn7_in, sd7_in, tn7_in;
   logic     ins7_in;
   geo_type  geo7_in;
   wide_type sn7_ff, sd7_ff, tn7_ff, td7_ff;
   always_comb begin
      sn7_in  = sn6_ff;
      sd7_in  = sd6_ff;
      tn7_in  = tn6_ff;
      ins7_in = geo6_ff.interior;
      if (tn6_ff < 0) begin
         tn7_in  = '0;
         ins7_in = 1'b0;
         if (nd6_ff < 0) begin
            sn7_in = '0;
         end else if (nd6_ff > a6_ff) begin
            sn7_in = sd6_ff;
         end else begin
            sn7_in = WIDE_W'(nd6_ff);
            sd7_in = WIDE_W'(a6_ff);
         end
      end else if (td6_ff < tn6_ff) begin
         tn7_in  = td6_ff;
         ins7_in = 1'b0;
         if (bd6_ff < 0) begin
            sn7_in = '0;
         end else if (bd6_ff > a6_ff) begin
            sn7_in = sd6_ff;
         end else begin
            sn7_in = WIDE_W'(bd6_ff);
            sd7_in = WIDE_W'(a6_ff);
         end
      end
      geo7_in          = geo6_ff;
      geo7_in.interior = ins7_in;
   end
   always_ff @(posedge clock) begin
      sn7_ff <= sn7_in;
      sd7_ff <= sd7_in;
      tn7_ff <= tn7_in;
      td7_ff <= td6_ff;
      geo7_ff <= geo7_in;
   end

   // Stages 8 to 8 + FRACTION_BITS: the two divisions, with the geometry and
   // the valid bit delayed alongside them.
   logic [FRACTION_BITS:0] s_quo, t_quo;

   scp_frac #(.FRACTION_BITS(FRACTION_BITS)) u_s_frac (
      .clock (clock),
      .num   (sn7_ff),
      .den   (sd7_ff),
      .quo   (s_quo)
   );

   scp_frac #(.FRACTION_BITS(FRACTION_BITS)) u_t_frac (
      .clock (clock),
      .num   (tn7_ff),
      .den   (td7_ff),
      .quo   (t_quo)
   );

   geo_type geod_ff [0:FRACTION_BITS];
   logic    vd_ff   [0:FRACTION_BITS];

   always_ff @(posedge clock) begin
      geod_ff[0] <= geo7_ff;
      for (int i = 0; i < FRACTION_BITS; i++) begin
         geod_ff[i+1] <= geod_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= FRACTION_BITS; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else begin
         vd_ff[0] <= v7_ff;
         for (int i = 0; i < FRACTION_BITS; i++) begin
            vd_ff[i+1] <= vd_ff[i];
         end
      end
   end

   // Foot stage 1: parameter times direction.
   logic signed [PW-1:0] pax_ff, pay_ff, pbx_ff, pby_ff;
   geo_type              geom_ff;
   logic                 vm_ff;
   always_ff @(posedge clock) begin
      pax_ff  <= $signed({1'b0, s_quo}) * geod_ff[FRACTION_BITS].dax;
      pay_ff  <= $signed({1'b0, s_quo}) * geod_ff[FRACTION_BITS].day;
      pbx_ff  <= $signed({1'b0, t_quo}) * geod_ff[FRACTION_BITS].dbx;
      pby_ff  <= $signed({1'b0, t_quo}) * geod_ff[FRACTION_BITS].dby;
      geom_ff <= geod_ff[FRACTION_BITS];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else begin
         vm_ff <= vd_ff[FRACTION_BITS];
      end
   end

   // Foot stage 2: round to nearest, halves upward, and add the start point.
   logic signed [PW-1:0] rax, ray, rbx, rby;
   always_comb begin
      rax = (pax_ff + HALF) >>> FRACTION_BITS;
      ray = (pay_ff + HALF) >>> FRACTION_BITS;
      rbx = (pbx_ff + HALF) >>> FRACTION_BITS;
      rby = (pby_ff + HALF) >>> FRACTION_BITS;
   end

   always_ff @(posedge clock) begin
      rsp_item.foot_a_x      <= geom_ff.ax + rax[COORD_BITS-1:0];
      rsp_item.foot_a_y      <= geom_ff.ay + ray[COORD_BITS-1:0];
      rsp_item.foot_b_x      <= geom_ff.bx + rbx[COORD_BITS-1:0];
      rsp_item.foot_b_y      <= geom_ff.by + rby[COORD_BITS-1:0];
      rsp_item.interior_feet <= geom_ff.interior;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= vm_ff;
      end
   end

`ifndef SYNTHESIS
   // With no clamp, s must already lie in [0, 1].
   a_s_in_range: assert property (@(posedge clock) disable iff (reset)
      (v7_ff && geo7_ff.interior) |-> (sn7_ff >= 0 && sn7_ff <= sd7_ff))
      else $error("unclamped s numerator outside its range");

   // With no clamp, t must already lie in [0, 1].
   a_t_in_range: assert property (@(posedge clock) disable iff (reset)
      (v7_ff && geo7_ff.interior) |-> (tn7_ff >= 0 && tn7_ff <= td7_ff))
      else $error("unclamped t numerator outside its range");

   // A negative t numerator is clamped to zero and clears the flag.
   a_t_clamp: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && tn6_ff < 0) |=> (tn7_ff == 0 && !geo7_ff.interior))
      else $error("t clamp at zero not applied");

   // Reset empties the pipeline, so no result follows a reset cycle.
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");
`endif

endmodule

// ===== tb/segment_closest_points_2d_test.sv =====
// Testbench for the 2D segment closest-points block: directed and random beats.
`timescale 1ns / 100ps

module segment_closest_points_2d_test;
   import scp_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   // Our own copy of the parallel threshold, kept in step with every write.
   logic [LIMIT_W-1:0] limit_copy = LIMIT_W'(1);
   rsp_type feet_pending[$];
   int errors = 0;
   bit quiet_tail = 0;

   segment_closest_points_2d #(.FRACTION_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // Parameter as floor(n * 2^FRAC / d), clamped to the range [0, 1.0].
   function automatic longint param_of(logic signed [127:0] n, logic signed [127:0] d);
      logic signed [127:0] rem;
      longint q;
      q = 0;
      rem = n;
      if (d <= 0 || n <= 0) return 0;
      if (n >= d) return longint'(1) << FRAC;
      for (int i = 0; i < FRAC; i++) begin
         rem = rem <<< 1;
         q = q << 1;
         if (rem >= d) begin
            rem = rem - d;
            q = q | 1;
         end
      end
      return q;
   endfunction

   // Foot coordinate: start + param*dir / 2^FRAC, halves rounded upward.
   function automatic coord_type foot_of(longint st, longint dir, longint par);
      longint p;
      p = par * dir + (longint'(1) << (FRAC - 1));
      return coord_type'(st + (p >>> FRAC));
   endfunction

   function automatic rsp_type closest_feet(req_type r);
      longint ax, ay, bx, by, dax, day, dbx, dby, wx, wy, a, b, c, d, e;
      logic signed [127:0] den, sn, sd, tn, td;
      longint sc, tc;
      rsp_type o;
      bit interior;
      interior = 1;
      ax = r.a_start_x; ay = r.a_start_y; bx = r.b_start_x; by = r.b_start_y;
      dax = longint'(r.a_end_x) - ax; day = longint'(r.a_end_y) - ay;
      dbx = longint'(r.b_end_x) - bx; dby = longint'(r.b_end_y) - by;
      wx = ax - bx; wy = ay - by;
      a = dax * dax + day * day;
      b = dax * dbx + day * dby;
      c = dbx * dbx + dby * dby;
      d = dax * wx + day * wy;
      e = dbx * wx + dby * wy;
      den = 128'(signed'(a)) * c - 128'(signed'(b)) * b;
      sd = den;
      td = den;
      if (den < signed'({108'd0, limit_copy})) begin
         // Nearly parallel: pin s at 0 and search t against B alone.
         sn = 0; sd = 1; tn = e; td = c;
      end else begin
         sn = 128'(signed'(b)) * e - 128'(signed'(c)) * d;
         tn = 128'(signed'(a)) * e - 128'(signed'(b)) * d;
         if (sn < 0) begin
            sn = 0; tn = e; td = c; interior = 0;
         end else if (sn > sd) begin
            sn = sd; tn = e + b; td = c; interior = 0;
         end
      end
      if (tn < 0) begin
         tn = 0;
         if (-d < 0) sn = 0;
         else if (-d > a) sn = sd;
         else begin
            sn = -d; sd = a;
         end
         interior = 0;
      end else if (tn > td) begin
         tn = td;
         if (b - d < 0) sn = 0;
         else if (b - d > a) sn = sd;
         else begin
            sn = b - d; sd = a;
         end
         interior = 0;
      end
      sc = param_of(sn, sd);
      tc = param_of(tn, td);
      o.foot_a_x = foot_of(ax, dax, sc);
      o.foot_a_y = foot_of(ay, day, sc);
      o.foot_b_x = foot_of(bx, dbx, tc);
      o.foot_b_y = foot_of(by, dby, tc);
      o.interior_feet = interior;
      return o;
   endfunction

   // Result checker: every strobe must match the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (feet_pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
            errors++;
         end else begin
            want = feet_pending.pop_front();
            if (rsp_item.foot_a_x !== want.foot_a_x || rsp_item.foot_a_y !== want.foot_a_y ||
                rsp_item.foot_b_x !== want.foot_b_x || rsp_item.foot_b_y !== want.foot_b_y ||
                rsp_item.interior_feet !== want.interior_feet) begin
               $display("%0t: mismatch, expected %h, actual %h", $time, want, rsp_item);
               errors++;
            end
         end
      end
   end

   // Sends one beat, with an occasional random gap before it.
   task automatic send_segments(req_type r);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      feet_pending.push_back(closest_feet(r));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (feet_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_copy = v;
   endtask

   function automatic req_type rand_segments(bit short);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom});
      if (short) begin
         // Short segments near a random spot make interior feet and parallels likely.
         r.a_end_x = r.a_start_x + coord_type'($urandom_range(0, 64) - 32);
         r.a_end_y = r.a_start_y + coord_type'($urandom_range(0, 64) - 32);
         r.b_start_x = r.a_start_x + coord_type'($urandom_range(0, 64) - 32);
         r.b_start_y = r.a_start_y + coord_type'($urandom_range(0, 64) - 32);
         r.b_end_x = r.b_start_x + coord_type'($urandom_range(0, 64) - 32);
         r.b_end_y = r.b_start_y + coord_type'($urandom_range(0, 64) - 32);
      end
      return r;
   endfunction

   task automatic directed_cases;
      coord_type mx, mn;
      mx = 12'sh7FF;
      mn = 12'sh800;
      // Crossing segments give an interior pair.
      send_segments('{-16, -16, 16, 16, -16, 16, 16, -16});
      // Parallel horizontal segments.
      send_segments('{0, 0, 32, 0, 8, 16, 40, 16});
      // Collinear, disjoint, and parallel going the other way.
      send_segments('{0, 0, 32, 0, 64, 0, 48, 0});
      // Both segments degenerate, and each alone.
      send_segments('{5, 7, 5, 7, -3, 9, -3, 9});
      send_segments('{5, 7, 5, 7, -30, 9, 30, 9});
      send_segments('{-30, 9, 30, 9, 5, 7, 5, 7});
      // Clamps at either end of each segment.
      send_segments('{0, 0, 16, 0, 32, -8, 32, 8});
      send_segments('{0, 0, 16, 0, -32, -8, -32, 8});
      send_segments('{32, -8, 32, 8, 0, 0, 16, 0});
      send_segments('{-32, -8, -32, 8, 0, 0, 16, 0});
      // Full-range extremes.
      send_segments('{mn, mn, mx, mx, mn, mx, mx, mn});
      send_segments('{mx, mx, mn, mn, mx, mx, mn, mn});
      send_segments('{mn, mn, mn, mx, mx, mn, mx, mx});
      send_segments('{mx, mn, mn, mx, 0, 0, 1, -1});
      send_segments('{0, 0, 0, 0, 0, 0, 0, 0});
      send_segments('{-1, -1, -1, -1, -1, -1, -1, -1});
      send_segments('{mn, mn, mn, mn, mx, mx, mx, mx});
   endtask

   task automatic limit_settings;
      // Zero limit lets an exact zero denominator take the general path.
      write_limit('0);
      send_segments('{0, 0, 32, 0, 8, 16, 40, 16});
      send_segments('{0, 0, 0, 0, 3, 3, 3, 3});
      write_limit('1);
      send_segments('{-16, -16, 16, 16, -16, 16, 16, -16});
      send_segments('{-2048, -2048, 2047, 2047, -2048, 2047, 2047, -2048});
      for (int i = 0; i < 30; i++) send_segments(rand_segments(1));
      write_limit(20'd50);
      for (int i = 0; i < 30; i++) send_segments(rand_segments(1));
   endtask

   task automatic random_mix;
      for (int i = 0; i < 600; i++) begin
         if (i == 300) write_limit(LIMIT_W'($urandom));
         if (i == 450) begin
            write_limit(20'd1);
            quiet_tail = 1;
         end
         send_segments(rand_segments($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_cases();
      limit_settings();
      random_mix();
      drain();
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
